// File: sv/qdp_pkg.sv
package qdp_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CODE_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int KEY_W    = 13;
  localparam logic [KEY_W-1:0] KEY_RESET = 13'h051D;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } level_t;

  // In-phase axis uses Gray order on the two high bits.
  localparam logic [1:0] GRAY_HI [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

  function automatic level_t level_index(input logic signed [SAMPLE_W-1:0] v);
    level_t r;
    r = '{ok: 1'b1, idx: 2'd0};
    case (v)
      -8'sd3: r.idx = 2'd0;
      -8'sd1: r.idx = 2'd1;
      8'sd1:  r.idx = 2'd2;
      8'sd3:  r.idx = 2'd3;
      default: r = '{ok: 1'b0, idx: 2'd0};
    endcase
    return r;
  endfunction

endpackage

// File: sv/qam16_demap_descramble_pack.sv
// A request accepted into the input register has its byte in the output register
// when it moves on as the second symbol of a pair; first symbols give no byte.
// Throughput: one symbol per cycle while the output is not stalled, one byte every
// two symbols, set by the input and output registers each holding one request.
// Reset (synchronous, active high) empties both registers, clears key index and the
// held half byte, and loads the key register with 0x051D.
module qam16_demap_descramble_pack
  import qdp_pkg::*;
#(
  parameter int KEY_BITS = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [KEY_W-1:0]  cfg_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // real_sample [7:0], imag_sample [15:8]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata    // data_byte [7:0]
);

  logic [KEY_W-1:0]           key_pattern;
  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] real_sample;
  logic signed [SAMPLE_W-1:0] imag_sample;
  logic [CODE_W-1:0]          code;
  logic [CODE_W-1:0]          nib;
  logic [CODE_W-1:0]          held_nibble;
  logic                       nibble_valid;
  logic                       out_free;
  logic                       advance;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  // A first symbol only fills the half-byte holder, so it never waits on the output.
  assign advance = in_valid && (!nibble_valid || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pattern <= KEY_RESET;
    end else if (cfg_we) begin
      key_pattern <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      real_sample <= s_axis_tdata[SAMPLE_W-1:0];
      imag_sample <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  qdp_slicer u_slicer (
    .real_sample (real_sample),
    .imag_sample (imag_sample),
    .code        (code)
  );

  qdp_descramble #(
    .KEY_BITS (KEY_BITS)
  ) u_descramble (
    .clk         (clk),
    .rst         (rst),
    .key_pattern (key_pattern),
    .code        (code),
    .step        (advance),
    .nib         (nib)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_valid  <= 1'b0;
      held_nibble   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        nibble_valid <= !nibble_valid;
        held_nibble  <= nibble_valid ? '0 : nib;
      end
      if (advance && nibble_valid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && nibble_valid) begin
      m_axis_tdata <= {held_nibble, nib};
    end
  end

endmodule

// File: sv/qdp_slicer.sv
module qdp_slicer
  import qdp_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] real_sample,
  input  logic signed [SAMPLE_W-1:0] imag_sample,
  output logic        [CODE_W-1:0]   code
);

  level_t re_lvl;
  level_t im_lvl;

  always_comb begin
    re_lvl = level_index(real_sample);
    im_lvl = level_index(imag_sample);
    // Any level off the grid on either axis gives code zero.
    if (re_lvl.ok && im_lvl.ok) begin
      code = {GRAY_HI[re_lvl.idx], im_lvl.idx};
    end else begin
      code = '0;
    end
  end

endmodule

// File: sv/qdp_descramble.sv
module qdp_descramble
  import qdp_pkg::*;
#(
  parameter int KEY_BITS = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KEY_W-1:0]  key_pattern,
  input  logic [CODE_W-1:0] code,
  input  logic              step,
  output logic [CODE_W-1:0] nib
);

  localparam int IDX_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_BITS - 1);

  logic [KEY_BITS-1:0] key_ext;
  logic [IDX_W-1:0]    key_index;
  logic [IDX_W-1:0]    key_index_next;
  logic [IDX_W-1:0]    idx [CODE_W+1];

  // Key bits above the register width read as zero.
  for (genvar i = 0; i < KEY_BITS; i++) begin : g_key
    if (i < KEY_W) begin : g_reg
      assign key_ext[i] = key_pattern[i];
    end else begin : g_zero
      assign key_ext[i] = 1'b0;
    end
  end

  // Four key positions per symbol, each wrapping at the key length.
  always_comb begin
    idx[0] = key_index;
    for (int k = 0; k < CODE_W; k++) begin
      nib[CODE_W-1-k] = code[CODE_W-1-k] ^ key_ext[idx[k]];
      idx[k+1] = (idx[k] == IDX_LAST) ? '0 : idx[k] + 1'b1;
    end
    key_index_next = idx[CODE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_index <= '0;
    end else if (step) begin
      key_index <= key_index_next;
    end
  end

endmodule

// File: verif/tb_qam16_demap_descramble_pack.sv
module tb_qam16_demap_descramble_pack;
  import qdp_pkg::*;

  localparam int KEY_LEN = 13;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_SYMBOLS = 275;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0] re;
    logic [7:0] im;
    logic       known;
    logic [7:0] known_byte;
  } symbol_row_t;

  // Rows with a known byte were worked out by hand from the reset key.
  localparam symbol_row_t DIRECTED [25] = '{
    '{8'h80, 8'h7F, 1'b0, 8'h00},
    '{8'h7F, 8'h80, 1'b1, 8'hB8},
    '{8'h03, 8'h03, 1'b0, 8'h00},
    '{8'hFD, 8'hFD, 1'b1, 8'h15},
    '{8'hFD, 8'hFD, 1'b0, 8'h00},
    '{8'hFD, 8'hFF, 1'b0, 8'h00},
    '{8'hFD, 8'h01, 1'b0, 8'h00},
    '{8'hFD, 8'h03, 1'b0, 8'h00},
    '{8'hFF, 8'hFD, 1'b0, 8'h00},
    '{8'hFF, 8'hFF, 1'b0, 8'h00},
    '{8'hFF, 8'h01, 1'b0, 8'h00},
    '{8'hFF, 8'h03, 1'b0, 8'h00},
    '{8'h01, 8'hFD, 1'b0, 8'h00},
    '{8'h01, 8'hFF, 1'b0, 8'h00},
    '{8'h01, 8'h01, 1'b0, 8'h00},
    '{8'h01, 8'h03, 1'b0, 8'h00},
    '{8'h03, 8'hFD, 1'b0, 8'h00},
    '{8'h03, 8'hFF, 1'b0, 8'h00},
    '{8'h03, 8'h01, 1'b0, 8'h00},
    '{8'h03, 8'h03, 1'b0, 8'h00},
    '{8'h00, 8'h01, 1'b0, 8'h00},
    '{8'h01, 8'h02, 1'b0, 8'h00},
    '{8'hFC, 8'h04, 1'b0, 8'h00},
    '{8'h03, 8'hFE, 1'b0, 8'h00},
    '{8'hFF, 8'h05, 1'b0, 8'h00}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [KEY_W-1:0]  cfg_data;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // real_sample [7:0], imag_sample [15:8]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [BYTE_W-1:0] m_axis_tdata;   // data_byte [7:0]

  // Descrambler state as seen by the checker.
  logic [KEY_W-1:0] key_reg = KEY_RESET;
  int unsigned      key_pos = 0;
  logic [3:0]       half_byte = 4'h0;
  bit               half_full = 1'b0;

  logic [7:0]  bytes_due [$];
  logic [7:0]  due_byte;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned sink_count = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  qam16_demap_descramble_pack dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns {on_grid, position}; position 0..3 stands for -3, -1, 1, 3.
  function automatic logic [2:0] grid_level(input logic [7:0] v);
    case (v)
      8'hFD:   return 3'b100;
      8'hFF:   return 3'b101;
      8'h01:   return 3'b110;
      8'h03:   return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  function automatic logic [3:0] symbol_code(input logic [7:0] re, input logic [7:0] im);
    logic [2:0] lr;
    logic [2:0] li;
    lr = grid_level(re);
    li = grid_level(im);
    if (!lr[2] || !li[2]) return 4'h0;
    // In-phase position goes through a Gray code, quadrature stays binary.
    return {lr[1:0] ^ {1'b0, lr[1]}, li[1:0]};
  endfunction

  function automatic bit descramble_symbol(input logic [7:0] re, input logic [7:0] im,
                                           output logic [7:0] full_byte);
    logic [3:0] code;
    logic [3:0] nib;
    code = symbol_code(re, im);
    for (int b = 3; b >= 0; b--) begin
      nib[b] = code[b] ^ key_reg[key_pos];
      key_pos = (key_pos + 1) % KEY_LEN;
    end
    full_byte = {half_byte, nib};
    if (!half_full) begin
      half_byte = nib;
      half_full = 1'b1;
      return 1'b0;
    end
    half_byte = 4'h0;
    half_full = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0:       return 8'hFD;
        1:       return 8'hFF;
        2:       return 8'h01;
        default: return 8'h03;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_symbol(input logic [7:0] re, input logic [7:0] im,
                             input logic known, input logic [7:0] known_byte);
    int unsigned gap;
    logic [7:0]  pred;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {im, re};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (descramble_symbol(re, im, pred)) bytes_due = {bytes_due, (known ? known_byte : pred)};
  endtask

  // A first symbol leaves no byte behind, so give the pipeline time to empty
  // after the last byte before touching the key.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [KEY_W-1:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we  <= 1'b0;
    key_reg = v;
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] next_key;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_symbol(DIRECTED[i].re, DIRECTED[i].im, DIRECTED[i].known, DIRECTED[i].known_byte);
    end

    for (int p = 0; p < 6; p++) begin
      drain_and_settle();
      case (p)
        0:       next_key = '0;
        1:       next_key = '1;
        default: next_key = KEY_W'($urandom_range(0, 8191));
      endcase
      write_key(next_key);
      tx_idle = (p % 3 != 2);
      rx_idle = (p % 3 != 1);
      repeat (PHASE_SYMBOLS) send_symbol(pick_level(), pick_level(), 1'b0, 8'h00);
    end

    s_axis_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : sink
    int unsigned pause;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      pause = rx_idle ? $urandom_range(0, 10) : 0;
      // One long hold-off lets the block fill up and push back on its input.
      if (sink_count == 120) pause = LONG_HOLD;
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sink_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bytes_due.size() == 0) begin
          $error("data_byte: no byte expected, got %02h", m_axis_tdata);
          errors++;
        end else begin
          due_byte = bytes_due.pop_front();
          if (m_axis_tdata !== due_byte) begin
            $error("data_byte: expected %02h, got %02h", due_byte, m_axis_tdata);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

endmodule

// File: files.f
sv/qdp_pkg.sv
sv/qdp_slicer.sv
sv/qdp_descramble.sv
sv/qam16_demap_descramble_pack.sv
verif/tb_qam16_demap_descramble_pack.sv
